### design/sormt_pkg.sv
// Shared types, constants and helpers for the sector overlay remap table.
// Used by the front, queue, back and checker modules; depends on nothing.
`timescale 1ns / 1ps

package sormt_pkg;

    localparam int SECTOR_W     = 32;
    localparam int ADDR_W       = 32;
    localparam int SLOT_W       = 10;
    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int MAX_TABLE_LIMIT = 'h1FA;
    localparam logic [ADDR_W-1:0] SLOT_ADDR_BIAS = 32'd4;
    localparam logic [SECTOR_W-1:0] OFFSET_RESET = 32'd64;
    localparam int QUEUE_DEPTH  = 2;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_OFFSET   = 1'b0;
    localparam logic CFG_OVERLAY_ENABLE = 1'b1;

    // Input access kinds on tuser.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Classification made by the front end.
    typedef enum logic [1:0] {
        KIND_READ_CARD,
        KIND_READ_LOOKUP,
        KIND_WRITE_IGNORED,
        KIND_WRITE
    } t_kind;

    typedef enum logic [1:0] {
        SRC_CARD = 2'd0,
        SRC_SAVE = 2'd1,
        SRC_NONE = 2'd2
    } t_source;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABORTED = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

    typedef struct packed {
        t_kind               kind;
        logic [SECTOR_W-1:0] sector;
        logic                last;
        logic [ADDR_W-1:0]   card_addr;
    } t_item;

    typedef struct packed {
        logic              persist;
        logic              new_entry;
        t_status           status;
        logic [ADDR_W-1:0] addr;
        t_source           source;
    } t_result;

    // Byte address of a save memory slot; slots are numbered from 1.
    function automatic logic [ADDR_W-1:0] slot_address(input logic [SLOT_W-1:0] slot);
        logic [ADDR_W-1:0] biased;
        biased = ADDR_W'(slot) + SLOT_ADDR_BIAS;
        return biased << SECTOR_SHIFT;
    endfunction

endpackage

### design/sormt_front.sv
// Front end: holds the configuration registers, accepts sector accesses and
// classifies them for the back end. Depends on sormt_pkg.
`timescale 1ns / 1ps

module sormt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_index,
    input  logic [sormt_pkg::SECTOR_W-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sormt_pkg::SECTOR_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output sormt_pkg::t_item              o_item
);

    logic [sormt_pkg::SECTOR_W-1:0] r_offset;
    logic                           r_enabled;
    logic [sormt_pkg::SECTOR_W-1:0] card_sector;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= sormt_pkg::OFFSET_RESET;
            r_enabled <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sormt_pkg::CFG_IMAGE_OFFSET:   r_offset  <= i_cfg_data;
                sormt_pkg::CFG_OVERLAY_ENABLE: r_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;
    assign card_sector   = s_axis_tdata + r_offset;

    always_comb begin
        o_item.sector    = s_axis_tdata;
        o_item.last      = s_axis_tlast;
        o_item.card_addr = card_sector << sormt_pkg::SECTOR_SHIFT;
        priority if (s_axis_tuser == sormt_pkg::OP_READ) begin
            o_item.kind = r_enabled ? sormt_pkg::KIND_READ_LOOKUP
                                    : sormt_pkg::KIND_READ_CARD;
        end else begin
            o_item.kind = r_enabled ? sormt_pkg::KIND_WRITE
                                    : sormt_pkg::KIND_WRITE_IGNORED;
        end
    end

endmodule

### design/sormt_queue.sv
// Short queue of classified accesses between the front and back ends.
// Depends on sormt_pkg.
`timescale 1ns / 1ps

module sormt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sormt_pkg::t_item i_item,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output sormt_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(sormt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(sormt_pkg::QUEUE_DEPTH + 1);

    sormt_pkg::t_item r_data [sormt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(sormt_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_data[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(sormt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(sormt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_item;
        end
    end

endmodule

### design/sormt_back.sv
// Back end: owns the overlay table memory, scans it one slot per cycle,
// resolves each access and holds the result register. Depends on sormt_pkg.
`timescale 1ns / 1ps

module sormt_back #(
    parameter int TABLE_SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  sormt_pkg::t_item   i_item,
    output logic               o_item_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sormt_pkg::t_result o_out
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CAP_INT = (sormt_pkg::MAX_TABLE_LIMIT + 1 < TABLE_SLOTS - 1)
                             ? sormt_pkg::MAX_TABLE_LIMIT + 1 : TABLE_SLOTS - 1;
    localparam logic [sormt_pkg::SLOT_W-1:0] CAPACITY = CAP_INT[sormt_pkg::SLOT_W-1:0];

    logic [sormt_pkg::SECTOR_W-1:0] r_table [TABLE_SLOTS];

    sormt_pkg::t_back_state r_state;
    sormt_pkg::t_back_state n_state;
    sormt_pkg::t_item       r_item;
    logic [sormt_pkg::SLOT_W-1:0]   r_idx;
    logic [sormt_pkg::SLOT_W-1:0]   r_cmp_idx;
    logic                           r_cmp_valid;
    logic [sormt_pkg::SECTOR_W-1:0] r_rd_data;
    logic [sormt_pkg::SLOT_W-1:0]   r_used;
    logic                           r_failed;
    logic                           r_out_valid;
    sormt_pkg::t_result             r_out;

    logic                           out_free;
    logic                           needs_scan;
    logic                           scan_hit;
    logic                           scan_done;
    logic                           res_fire;
    logic                           res_append;
    logic                           res_full;
    logic [sormt_pkg::SLOT_W-1:0]   next_slot;
    sormt_pkg::t_item               res_item;
    sormt_pkg::t_result             res;

    assign next_slot = r_used + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sormt_pkg::BK_IDLE: if (o_item_pop && needs_scan) n_state = sormt_pkg::BK_SCAN;
            sormt_pkg::BK_SCAN: if (scan_done) n_state = sormt_pkg::BK_IDLE;
            default:            n_state = sormt_pkg::BK_IDLE;
        endcase
    end

    // Control and result resolution.
    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        o_item_pop = (r_state == sormt_pkg::BK_IDLE) && i_item_valid && out_free;
        // A scan is only worth starting when the table has entries and the
        // access would look at them.
        needs_scan = (r_used != '0) &&
                     ((i_item.kind == sormt_pkg::KIND_READ_LOOKUP) ||
                      (i_item.kind == sormt_pkg::KIND_WRITE && !r_failed));
        scan_hit   = r_cmp_valid && (r_rd_data == r_item.sector);
        scan_done  = scan_hit || (r_cmp_valid && (r_cmp_idx == r_used));
        res_item   = (r_state == sormt_pkg::BK_SCAN) ? r_item : i_item;
        res_fire   = (o_item_pop && !needs_scan) ||
                     ((r_state == sormt_pkg::BK_SCAN) && scan_done);

        res_append    = 1'b0;
        res_full      = 1'b0;
        res.persist   = 1'b0;
        res.new_entry = 1'b0;
        res.status    = sormt_pkg::ST_OK;
        res.addr      = '0;
        res.source    = sormt_pkg::SRC_NONE;
        unique case (res_item.kind)
            sormt_pkg::KIND_READ_CARD: begin
                res.source = sormt_pkg::SRC_CARD;
                res.addr   = res_item.card_addr;
            end
            sormt_pkg::KIND_READ_LOOKUP: begin
                if (scan_hit) begin
                    res.source = sormt_pkg::SRC_SAVE;
                    res.addr   = sormt_pkg::slot_address(r_cmp_idx);
                end else begin
                    res.source = sormt_pkg::SRC_CARD;
                    res.addr   = res_item.card_addr;
                end
            end
            sormt_pkg::KIND_WRITE_IGNORED: begin
                res.status = sormt_pkg::ST_IGNORED;
            end
            sormt_pkg::KIND_WRITE: begin
                priority if (r_failed) begin
                    res.status = sormt_pkg::ST_ABORTED;
                end else if (scan_hit) begin
                    res.source  = sormt_pkg::SRC_SAVE;
                    res.addr    = sormt_pkg::slot_address(r_cmp_idx);
                    res.persist = res_item.last;
                end else if (r_used >= CAPACITY) begin
                    res.status = sormt_pkg::ST_FULL;
                    res_full   = 1'b1;
                end else begin
                    res_append    = 1'b1;
                    res.source    = sormt_pkg::SRC_SAVE;
                    res.addr      = sormt_pkg::slot_address(next_slot);
                    res.new_entry = 1'b1;
                    res.persist   = res_item.last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sormt_pkg::BK_IDLE;
            r_cmp_valid <= 1'b0;
            r_used      <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sormt_pkg::BK_SCAN && !scan_done) begin
                r_cmp_valid <= (r_idx <= r_used);
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (res_fire) begin
                r_out_valid <= 1'b1;
                if (res_append) begin
                    r_used <= next_slot;
                end
                // The last item of a request closes it, failed or not.
                if (res_item.last) begin
                    r_failed <= 1'b0;
                end else if (res_full) begin
                    r_failed <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_item <= i_item;
            r_idx  <= sormt_pkg::SLOT_W'(1);
        end else if (r_state == sormt_pkg::BK_SCAN) begin
            r_idx <= r_idx + 1'b1;
        end
        r_cmp_idx <= r_idx;
        if (res_fire) begin
            r_out <= res;
        end
    end

    // Table memory: one write port for appends, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (res_fire && res_append) begin
            r_table[next_slot[AW-1:0]] <= res_item.sector;
        end
        r_rd_data <= r_table[r_idx[AW-1:0]];
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### design/sector_overlay_remap_table_top.sv
// Top level of the sector overlay remap table: front end, queue, back end.
// Depends on sormt_pkg, sormt_front, sormt_queue and sormt_back.
//
// Usage: each s_axis transaction is one sector access (tuser: 0 read,
// 1 write; tdata: sector; tlast: last sector of the request). Each access
// yields exactly one m_axis transaction with the routing decision. The
// configuration channel (i_cfg_*) is always ready; index 0 is the image
// sector offset, index 1 the overlay enable. Write it only while idle.
// Accesses that need no table lookup (card reads with the overlay off,
// ignored or aborted writes, any access while the table is empty) are
// resolved one per cycle while the receiver keeps up. A lookup scans the
// table through its single read port, one slot per cycle, from slot 1
// up to the first match or the last used slot.
// Reset empties the table, clears the request failure flag and restores
// the register defaults (offset 64, overlay enabled); no clearing pass.
// When the receiver stalls, the result register holds its transaction,
// the back end stops, and the two-entry queue fills before s_axis_tready
// drops.
`timescale 1ns / 1ps

module sector_overlay_remap_table_top #(
    parameter int TABLE_SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Sector accesses in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sector
    input  logic        s_axis_tuser,   // [0] op
    input  logic        s_axis_tlast,
    // Routing results out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] target_address
    output logic [5:0]  m_axis_tuser    // [1:0] source, [3:2] status,
                                        // [4] new_entry, [5] persist_table
);

    logic               push;
    logic               queue_full;
    logic               queue_valid;
    logic               pop;
    sormt_pkg::t_item   front_item;
    sormt_pkg::t_item   queue_item;
    sormt_pkg::t_result result;

    sormt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    sormt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_item  (queue_item)
    );

    sormt_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_item_pop   (pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out        (result)
    );

    assign m_axis_tdata = result.addr;
    assign m_axis_tuser = {result.persist, result.new_entry, result.status, result.source};

endmodule

### design/sormt_checker.sv
// Port-level checks on the result channel of the remap table top level.
// Depends on sormt_pkg; bound to sector_overlay_remap_table_top below.
`timescale 1ns / 1ps

module sormt_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [5:0]  m_axis_tuser
);

    logic [1:0] source;
    logic [1:0] status;

    assign source = m_axis_tuser[1:0];
    assign status = m_axis_tuser[3:2];

    // A stalled result transaction stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Any non-ok status means the sector goes nowhere.
    a_fail_nowhere: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != sormt_pkg::ST_OK |-> source == sormt_pkg::SRC_NONE)
        else $error("failed access still routed");

    // Nowhere carries a zero address and never an ok status.
    a_nowhere_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && source == sormt_pkg::SRC_NONE |->
        m_axis_tdata == '0 && status != sormt_pkg::ST_OK)
        else $error("nowhere result with address or ok status");

    // Appends and persist requests only come with a save memory slot.
    a_save_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[4] || m_axis_tuser[5]) |->
        source == sormt_pkg::SRC_SAVE && status == sormt_pkg::ST_OK)
        else $error("append or persist without a slot");

endmodule

bind sector_overlay_remap_table_top sormt_port_checker u_sormt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
